// File: src/etd_pkg.sv
package etd_pkg;

   localparam int WORD_W = 32;
   localparam int TAG_W  = 8;
   localparam int ACT_W  = 2;
   localparam int CNT_W  = 6;
   localparam int CSR_W  = 2;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [TAG_W-1:0]  tag_type;

   // largest field tag; tag t addresses table entry t-1
   localparam tag_type TAG_MAX = tag_type'(255);
   localparam tag_type TAG_TIMESTAMP = '0;

   // action codes carried on req_tuser
   localparam logic [ACT_W-1:0] ACT_START = 2'd0;
   localparam logic [ACT_W-1:0] ACT_TOKEN = 2'd1;
   localparam logic [ACT_W-1:0] ACT_END   = 2'd2;

   // result kinds carried on rsp_tuser
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   // register indexes
   localparam logic [CSR_W-1:0] CSR_RAW_MODE    = 2'd0;
   localparam logic [CSR_W-1:0] CSR_FIELD_COUNT = 2'd1;
   localparam logic [CSR_W-1:0] CSR_BASE_STAMP  = 2'd2;
   localparam logic [CSR_W-1:0] CSR_OUT_LIMIT   = 2'd3;

   // one result item as held in the output register
   typedef struct packed {
      logic     kind;
      word_type word;
      logic     last;
   } rsp_type;

endpackage

// File: src/etd_ram.sv
module etd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/event_trail_edge_decoder_top.sv
// Flow: a raw field token goes through S_RAW into the output register; a timestamp token
//   with no event open goes through S_FLUSH and S_TS before its timestamp is loaded.
// Items: a stored field token or a start is taken in S_IDLE; closing an event reads each
//   table entry in edge mode (field RAM read, then output load), then loads the 0 word, and
//   no new item is taken until a timestamp or end item has been fully handled.
// Reset (synchronous, active high): registers to 0, running timestamp 0, table reads as 0
//   through per-entry valid bits, next token taken as a timestamp.
module event_trail_edge_decoder_top #(
   parameter int MAX_FIELDS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] token_value
   input  logic [1:0]  req_tuser,   // [1:0] action
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] word
   output logic        rsp_tuser,   // [0] kind
   output logic        rsp_tlast,
   // register writes
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int AW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
   localparam logic [etd_pkg::CNT_W-1:0] MAXF = etd_pkg::CNT_W'(MAX_FIELDS);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;  // take an item
   localparam logic [2:0] S_FLUSH = 3'd1;  // decide how to close the open event
   localparam logic [2:0] S_FRD   = 3'd2;  // field RAM read in flight
   localparam logic [2:0] S_FEM   = 3'd3;  // emit one table entry
   localparam logic [2:0] S_ZERO  = 3'd4;  // emit event terminator
   localparam logic [2:0] S_TS    = 3'd5;  // emit new timestamp
   localparam logic [2:0] S_RAW   = 3'd6;  // emit raw field token
   localparam logic [2:0] S_DONE  = 3'd7;  // emit trail done with count

   // configuration
   logic                        raw_ff;
   logic [etd_pkg::CNT_W-1:0]   fcount_ff;
   etd_pkg::word_type           base_ff;
   etd_pkg::word_type           limit_ff;

   // trail state
   logic [2:0]                  state_ff, state_in;
   logic [AW-1:0]               idx_ff, idx_in;
   etd_pkg::word_type           stamp_ff, stamp_in;
   etd_pkg::word_type           count_ff, count_in;
   logic                        open_ff, open_in;
   logic                        first_ff, first_in;
   logic                        end_ff, end_in;      // flush is for an end item
   etd_pkg::word_type           tok_ff, tok_in;
   logic [MAX_FIELDS-1:0]       valid_ff, valid_in;  // table entry written since start

   // output register
   logic                        out_valid_ff;
   etd_pkg::rsp_type            out_ff;
   logic                        ld;
   etd_pkg::rsp_type            ld_rsp;

   // field table RAM
   logic                        ram_we;
   logic [AW-1:0]               ram_waddr;
   etd_pkg::word_type           ram_rdata;

   logic                        req_fire;
   logic                        out_free;
   logic                        emit_ok;
   logic                        limit_hit;
   logic [etd_pkg::CNT_W-1:0]   active_n;
   etd_pkg::tag_type            tag;
   etd_pkg::tag_type            tag_m1;
   etd_pkg::word_type           stamp_sum;

   etd_ram #(
      .WIDTH (etd_pkg::WORD_W),
      .DEPTH (MAX_FIELDS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_tdata),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;

   // data words stop once the trail reaches the limit; a word that fills it is the item's last, but not in an end flush
   assign emit_ok   = count_ff < limit_ff;
   assign limit_hit = (count_ff + 32'd1) == limit_ff;

   assign active_n  = (fcount_ff > MAXF) ? MAXF : fcount_ff;
   assign tag       = req_tdata[etd_pkg::TAG_W-1:0];
   assign tag_m1    = tag - 8'd1;
   assign ram_waddr = AW'(tag_m1);
   assign stamp_sum = stamp_ff + {8'd0, tok_ff[31:etd_pkg::TAG_W]};

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      stamp_in = stamp_ff;
      count_in = count_ff;
      open_in  = open_ff;
      first_in = first_ff;
      end_in   = end_ff;
      tok_in   = tok_ff;
      valid_in = valid_ff;
      ram_we   = 1'b0;
      ld       = 1'b0;
      ld_rsp   = '{kind: etd_pkg::KIND_DATA, word: '0, last: 1'b0};

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_tuser)
                  etd_pkg::ACT_START: begin
                     stamp_in = base_ff;
                     valid_in = '0;
                     count_in = '0;
                     open_in  = 1'b0;
                     first_in = 1'b1;
                  end
                  etd_pkg::ACT_TOKEN: begin
                     tok_in = req_tdata;
                     if (first_ff || tag == etd_pkg::TAG_TIMESTAMP) begin
                        end_in   = 1'b0;
                        state_in = S_FLUSH;
                     end else if (raw_ff) begin
                        state_in = S_RAW;
                     end else if (tag_m1 < etd_pkg::TAG_W'(active_n)) begin
                        ram_we              = 1'b1;
                        valid_in[ram_waddr] = 1'b1;
                     end
                  end
                  etd_pkg::ACT_END: begin
                     end_in   = 1'b1;
                     state_in = S_FLUSH;
                  end
                  default: ;  // unused action code
               endcase
            end
         end
         S_FLUSH: begin
            if (!open_ff) begin
               state_in = end_ff ? S_DONE : S_TS;
            end else if (raw_ff || active_n == '0) begin
               state_in = S_ZERO;
            end else begin
               idx_in   = '0;
               state_in = S_FRD;
            end
         end
         S_FRD: begin
            state_in = S_FEM;
         end
         S_FEM: begin
            if (out_free || !emit_ok) begin
               if (emit_ok) begin
                  ld          = 1'b1;
                  ld_rsp.word = valid_ff[idx_ff] ? ram_rdata : '0;
                  ld_rsp.last = !end_ff && limit_hit;
                  count_in    = count_ff + 32'd1;
               end
               if (etd_pkg::CNT_W'(idx_ff) == active_n - 6'd1) begin
                  state_in = S_ZERO;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = S_FRD;
               end
            end
         end
         S_ZERO: begin
            if (out_free || !emit_ok) begin
               if (emit_ok) begin
                  ld          = 1'b1;
                  ld_rsp.last = !end_ff && limit_hit;
                  count_in    = count_ff + 32'd1;
               end
               open_in  = 1'b0;
               state_in = end_ff ? S_DONE : S_TS;
            end
         end
         S_TS: begin
            if (out_free || !emit_ok) begin
               if (emit_ok) begin
                  ld          = 1'b1;
                  ld_rsp.word = stamp_sum;
                  ld_rsp.last = 1'b1;
                  count_in    = count_ff + 32'd1;
               end
               stamp_in = stamp_sum;
               open_in  = 1'b1;
               first_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         S_RAW: begin
            if (out_free || !emit_ok) begin
               if (emit_ok) begin
                  ld          = 1'b1;
                  ld_rsp.word = tok_ff;
                  ld_rsp.last = 1'b1;
                  count_in    = count_ff + 32'd1;
               end
               state_in = S_IDLE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               ld          = 1'b1;
               ld_rsp.kind = etd_pkg::KIND_DONE;
               ld_rsp.word = count_ff;
               ld_rsp.last = 1'b1;
               first_in    = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control and trail state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         stamp_ff <= '0;
         count_ff <= '0;
         open_ff  <= 1'b0;
         first_ff <= 1'b1;
         end_ff   <= 1'b0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         stamp_ff <= stamp_in;
         count_ff <= count_in;
         open_ff  <= open_in;
         first_ff <= first_in;
         end_ff   <= end_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff    <= 1'b0;
         fcount_ff <= '0;
         base_ff   <= '0;
         limit_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            etd_pkg::CSR_RAW_MODE:    raw_ff    <= csr_wdata[0];
            etd_pkg::CSR_FIELD_COUNT: fcount_ff <= csr_wdata[etd_pkg::CNT_W-1:0];
            etd_pkg::CSR_BASE_STAMP:  base_ff   <= csr_wdata;
            etd_pkg::CSR_OUT_LIMIT:   limit_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // output register: refilled in the same cycle it drains
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (ld) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ld) begin
         out_ff <= ld_rsp;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.word;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.last;

   // data words only go out below the limit
   a_limit: assert property (@(posedge clock) disable iff (reset)
      (ld && ld_rsp.kind == etd_pkg::KIND_DATA) |-> (count_ff < limit_ff))
      else $error("data word loaded at or past output limit");

   // no table write while an event is being read out
   a_no_wr_flush: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !ram_we)
      else $error("field table written during flush");

   // a field read is always followed by the emit state, so the registered RAM output is ready before the entry is used
   a_rd_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FRD) |=> (state_ff == S_FEM))
      else $error("field read not followed by emit");

   // table index stays inside the active field range
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FEM) |-> (etd_pkg::CNT_W'(idx_ff) < active_n))
      else $error("field index past active count");

   // trail done is always the item's last result
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (ld && ld_rsp.kind == etd_pkg::KIND_DONE) |-> ld_rsp.last)
      else $error("done result not marked last");

endmodule

// File: tb/trail_decode_monitor.sv
`timescale 1ns / 100ps

// Watches both channels and the register port of the trail decoder, keeps its
// own copy of the decode state and checks every result item in order.
module trail_decode_monitor #(
   parameter int MAX_FIELDS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [31:0]      req_tdata,
   input  logic [1:0]       req_tuser,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [31:0]      rsp_tdata,
   input  logic             rsp_tuser,
   input  logic             rsp_tlast,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_wdata,
   output int               backlog,
   output int               fail_count
);

   // register copies
   logic                      cfg_raw;
   logic [etd_pkg::CNT_W-1:0] cfg_fields;
   etd_pkg::word_type         cfg_base;
   etd_pkg::word_type         cfg_limit;

   // decode state
   etd_pkg::word_type run_stamp;
   etd_pkg::word_type field_row [MAX_FIELDS];
   logic              event_pending;
   logic              take_stamp;
   etd_pkg::word_type emitted;

   etd_pkg::rsp_type decoded_words [$];

   function automatic int live_fields();
      return (int'(cfg_fields) > MAX_FIELDS) ? MAX_FIELDS : int'(cfg_fields);
   endfunction

   task automatic clear_row();
      for (int i = 0; i < MAX_FIELDS; i++)
         field_row[i] = '0;
   endtask

   task automatic push_result(input logic kind, input etd_pkg::word_type w);
      etd_pkg::rsp_type r;
      r.kind = kind;
      r.word = w;
      r.last = 1'b0;
      decoded_words.push_back(r);
   endtask

   // data words past the limit are dropped, count saturates
   task automatic emit_data(input etd_pkg::word_type w);
      if (emitted < cfg_limit) begin
         push_result(etd_pkg::KIND_DATA, w);
         emitted = emitted + 1;
      end
   endtask

   task automatic close_event();
      if (event_pending) begin
         if (!cfg_raw)
            for (int j = 0; j < live_fields(); j++)
               emit_data(field_row[j]);
         emit_data('0);
         event_pending = 1'b0;
      end
   endtask

   task automatic decode_item(input logic [etd_pkg::ACT_W-1:0] act,
                              input etd_pkg::word_type tok);
      int               held;
      int               idx;
      etd_pkg::tag_type tag;
      etd_pkg::rsp_type tail;
      held = decoded_words.size();
      tag  = tok[etd_pkg::TAG_W-1:0];
      idx  = int'(tag) - 1;
      case (act)
         etd_pkg::ACT_START: begin
            run_stamp     = cfg_base;
            clear_row();
            emitted       = '0;
            event_pending = 1'b0;
            take_stamp    = 1'b1;
         end
         etd_pkg::ACT_TOKEN: begin
            if (take_stamp || tag == etd_pkg::TAG_TIMESTAMP) begin
               close_event();
               run_stamp     = run_stamp + (tok >> etd_pkg::TAG_W);
               emit_data(run_stamp);
               event_pending = 1'b1;
               take_stamp    = 1'b0;
            end else if (cfg_raw) begin
               emit_data(tok);
            end else if (idx < live_fields()) begin
               field_row[idx] = tok;
            end
         end
         etd_pkg::ACT_END: begin
            close_event();
            push_result(etd_pkg::KIND_DONE, emitted);
            take_stamp = 1'b1;
         end
         default: ;
      endcase
      if (decoded_words.size() > held) begin
         tail      = decoded_words.pop_back();
         tail.last = 1'b1;
         decoded_words.push_back(tail);
      end
   endtask

   always @(posedge clock) begin
      etd_pkg::rsp_type want;
      if (reset) begin
         cfg_raw       = 1'b0;
         cfg_fields    = '0;
         cfg_base      = '0;
         cfg_limit     = '0;
         run_stamp     = '0;
         clear_row();
         event_pending = 1'b0;
         take_stamp    = 1'b1;
         emitted       = '0;
         decoded_words.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_words.size() == 0) begin
               $error("unexpected result item: kind %0d word %h last %0d",
                      rsp_tuser, rsp_tdata, rsp_tlast);
               fail_count++;
            end else begin
               want = decoded_words.pop_front();
               if (rsp_tuser !== want.kind) begin
                  $error("kind mismatch: expected %0d, got %0d", want.kind, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata !== want.word) begin
                  $error("word mismatch: expected %h, got %h", want.word, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last mismatch: expected %0d, got %0d", want.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               etd_pkg::CSR_RAW_MODE:    cfg_raw    = csr_wdata[0];
               etd_pkg::CSR_FIELD_COUNT: cfg_fields = csr_wdata[etd_pkg::CNT_W-1:0];
               etd_pkg::CSR_BASE_STAMP:  cfg_base   = csr_wdata;
               etd_pkg::CSR_OUT_LIMIT:   cfg_limit  = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            decode_item(req_tuser, req_tdata);
      end
      backlog <= decoded_words.size();
   end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

// Top of the trail decoder bench: clock, reset, item stimulus, random stalls
// on both channels, register phases, watchdog and verdict. All prediction and
// comparison lives in trail_decode_monitor.
module testbench;

   localparam int MAX_FIELDS   = 32;
   localparam int DRAIN_CYCLES = 100;   // worst flush: a full table of 32 entries, plus margin
   localparam int IDLE_LIMIT   = 2000;  // cycles without any handshake on either channel
   localparam int PHASE_ITEMS  = 35;
   localparam int PHASES       = 8;

   // action code the block does not use; must be ignored
   localparam logic [etd_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = etd_pkg::ACT_START;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = etd_pkg::CSR_RAW_MODE;
   logic [31:0] csr_wdata  = '0;

   int backlog;
   int fail_count;
   int items_sent = 0;
   int idle_cycles = 0;

   // calm phases run without gaps on either side
   bit                        calm = 1'b0;
   logic                      cur_raw = 1'b0;
   logic [etd_pkg::CNT_W-1:0] cur_count = '0;

   always #10 clock = ~clock;

   event_trail_edge_decoder_top #(
      .MAX_FIELDS(MAX_FIELDS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   trail_decode_monitor #(
      .MAX_FIELDS(MAX_FIELDS)
   ) trail_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .backlog    (backlog),
      .fail_count (fail_count)
   );

   // mostly short gaps, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // timestamp token; a nonzero tag only makes sense as a trail's first token
   function automatic etd_pkg::word_type make_stamp(input bit tagged_first);
      logic [23:0] delta;
      int          r;
      r = $urandom_range(0, 9);
      if (r == 0)      delta = '1;
      else if (r == 1) delta = '0;
      else if (r < 5)  delta = 24'($urandom_range(0, 255));
      else             delta = 24'($urandom);
      return {delta, tagged_first ? etd_pkg::tag_type'($urandom_range(1, 255))
                                  : etd_pkg::TAG_TIMESTAMP};
   endfunction

   // field token; in edge mode mostly a tag inside the active table
   function automatic etd_pkg::word_type make_field();
      int               cap;
      etd_pkg::tag_type tag;
      cap = (int'(cur_count) > MAX_FIELDS) ? MAX_FIELDS : int'(cur_count);
      if (cur_raw || cap == 0 || $urandom_range(0, 4) == 0)
         tag = etd_pkg::tag_type'($urandom_range(1, int'(etd_pkg::TAG_MAX)));
      else
         tag = etd_pkg::tag_type'($urandom_range(1, cap));
      return {24'($urandom), tag};
   endfunction

   // lower valid and hold off until every predicted result has come out
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (backlog != 0) @(posedge clock);
   endtask

   // one item: valid held until accepted, then maybe a gap or a full pause
   task automatic send_item(input logic [etd_pkg::ACT_W-1:0] act,
                            input etd_pkg::word_type tok);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= tok;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (calm) return;
      if ($urandom_range(0, 49) == 0) begin
         drain_results();
      end else begin
         gap = ($urandom_range(0, 1) == 0) ? 0 : idle_len();
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // registers change only with the block idle; all four written back to back
   task automatic configure(input logic raw, input logic [etd_pkg::CNT_W-1:0] count,
                            input etd_pkg::word_type base,
                            input etd_pkg::word_type limit);
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= etd_pkg::CSR_RAW_MODE;
      csr_wdata <= {31'd0, raw};
      @(posedge clock);
      csr_index <= etd_pkg::CSR_FIELD_COUNT;
      csr_wdata <= {26'd0, count};
      @(posedge clock);
      csr_index <= etd_pkg::CSR_BASE_STAMP;
      csr_wdata <= base;
      @(posedge clock);
      csr_index <= etd_pkg::CSR_OUT_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_raw   = raw;
      cur_count = count;
   endtask

   // a mostly well-formed trail with some noise and broken framing
   task automatic random_trail();
      int n_events;
      int n_fields;
      if ($urandom_range(0, 9) != 0) send_item(etd_pkg::ACT_START, $urandom);
      n_events = $urandom_range(0, 4);
      for (int e = 0; e < n_events; e++) begin
         send_item(etd_pkg::ACT_TOKEN, make_stamp(e == 0 && $urandom_range(0, 3) == 0));
         n_fields = $urandom_range(0, 6);
         for (int f = 0; f < n_fields; f++)
            send_item(etd_pkg::ACT_TOKEN, make_field());
         if ($urandom_range(0, 14) == 0)
            send_item(2'($urandom_range(0, 3)), $urandom);
      end
      if ($urandom_range(0, 9) != 0) send_item(etd_pkg::ACT_END, $urandom);
   endtask

   // result side: bursts of ready, then a random stall unless calm
   initial begin
      forever begin
         @(posedge clock);
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         if (!calm) begin
            rsp_tready <= 1'b0;
            repeat (idle_len()) @(posedge clock);
         end
      end
   end

   // watchdog on handshake progress
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int phase_goal;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: limit 0, so only the done item with count 0 comes out;
      // a token before any start is taken as a timestamp
      send_item(etd_pkg::ACT_TOKEN, 32'hFFFF_FF05);
      send_item(etd_pkg::ACT_END, '0);

      // edge mode, full table, base near wrap
      configure(1'b0, 6'd32, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
      send_item(etd_pkg::ACT_START, 32'hFFFF_FFFF);
      send_item(etd_pkg::ACT_TOKEN, 32'h1234_5605);   // first token, nonzero tag: timestamp, wraps the base
      send_item(etd_pkg::ACT_TOKEN, 32'hFFFF_FF01);   // lowest entry
      send_item(etd_pkg::ACT_TOKEN, 32'hA5A5_A520);   // highest entry
      send_item(etd_pkg::ACT_TOKEN, 32'h0000_0021);   // past the table: ignored
      send_item(etd_pkg::ACT_TOKEN, 32'hFFFF_FFFF);   // largest tag: ignored
      send_item(etd_pkg::ACT_TOKEN, 32'hFFFF_FF00);   // max delta, flushes full event
      send_item(etd_pkg::ACT_TOKEN, 32'h5A5A_5A02);
      drain_results();                                // sender waits for every result
      send_item(etd_pkg::ACT_END, '0);
      send_item(etd_pkg::ACT_TOKEN, 32'h0000_0A03);   // no new start: continuation, timestamp
      send_item(ACT_UNUSED, 32'hDEAD_BEEF);           // ignored
      send_item(etd_pkg::ACT_END, '0);
      send_item(etd_pkg::ACT_END, '0);                // nothing open, done only
      send_item(etd_pkg::ACT_START, '0);
      send_item(etd_pkg::ACT_TOKEN, 32'h0000_0100);
      send_item(etd_pkg::ACT_TOKEN, 32'h1111_1101);
      send_item(etd_pkg::ACT_START, '0);              // open event dropped unflushed
      send_item(etd_pkg::ACT_END, '0);

      // raw mode with a tiny output limit: words past it are dropped
      configure(1'b1, 6'd0, 32'h0000_0000, 32'd3);
      send_item(etd_pkg::ACT_START, '0);
      send_item(etd_pkg::ACT_TOKEN, 32'h0000_0700);
      send_item(etd_pkg::ACT_TOKEN, 32'h0000_0001);
      send_item(etd_pkg::ACT_TOKEN, 32'h8000_00FF);
      send_item(etd_pkg::ACT_TOKEN, 32'h0000_0102);   // over the limit
      send_item(etd_pkg::ACT_END, '0);                // count saturates

      phase_goal = items_sent;
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: configure(1'b0, 6'd32, $urandom, 32'hFFFF_FFFF);
            1: configure(1'b0, 6'd63, $urandom, $urandom_range(40, 120));
            2: configure(1'b1, 6'($urandom), $urandom, 32'hFFFF_FFFF);
            3: configure(1'b0, 6'd0, 32'h0000_0000, 32'hFFFF_FFFF);
            4: configure(1'b0, 6'($urandom_range(1, 8)), $urandom, $urandom_range(0, 60));
            5: configure(1'b1, 6'd5, 32'hFFFF_FFFF, 32'h0000_0000);
            6: configure(1'b0, 6'($urandom_range(1, 8)), $urandom, 32'hFFFF_FFFF);
            default: configure(1'b0, 6'd32, 32'h0000_0000, 32'd60);
         endcase
         calm = (p % 3 == 1);
         phase_goal += PHASE_ITEMS;
         while (items_sent < phase_goal) random_trail();
      end

      calm = 1'b0;
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: filelist.f
src/etd_pkg.sv
src/etd_ram.sv
src/event_trail_edge_decoder_top.sv
tb/trail_decode_monitor.sv
tb/testbench.sv
